/* rtl/kst_pkg.sv */
// shared types, constants and helpers for the keyed session table
package kst_pkg;

   localparam int TABLE_SLOTS = 16;
   localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

   localparam logic [15:0] EXPIRY_RESET = 16'd30;

   localparam logic [1:0] MODE_CREATE = 2'd0;
   localparam logic [1:0] MODE_FIND   = 2'd1;
   localparam logic [1:0] MODE_REMOVE = 2'd2;

   localparam logic [1:0] STATUS_CREATED   = 2'd0;
   localparam logic [1:0] STATUS_FOUND     = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_REMOVED   = 2'd3;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] created;
      logic [7:0]  cipher;
      logic [7:0]  key_index;
      logic [31:0] handle;
      logic [7:0]  xor_kind;
      logic [7:0]  client;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_COMMIT,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic start;
      logic read;
      logic eval;
      logic commit;
      logic load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_create;
      logic is_remove;
      logic match;
      logic last;
      logic out_busy;
   } ctrl_stat_type;

   // low four bits of a slot number, zero extended for small tables
   function automatic logic [3:0] slot_to_index(input logic [SLOT_W-1:0] slot);
      logic [SLOT_W+3:0] ext;
      ext = {4'b0000, slot};
      return ext[3:0];
   endfunction

endpackage

/* rtl/kst_ctrl.sv */
// sequencer that walks the slot table for one request
module kst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kst_pkg::ctrl_stat_type stat,
   output kst_pkg::ctrl_cmd_type  cmd
);

   kst_pkg::ctrl_state_type state_ff;
   kst_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kst_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kst_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = kst_pkg::ST_READ;
            end
         end
         kst_pkg::ST_READ: begin
            state_in = kst_pkg::ST_EVAL;
         end
         kst_pkg::ST_EVAL: begin
            if (stat.match) begin
               state_in = stat.is_remove ? kst_pkg::ST_COMMIT : kst_pkg::ST_DONE;
            end else if (stat.last) begin
               state_in = stat.is_create ? kst_pkg::ST_COMMIT : kst_pkg::ST_DONE;
            end else begin
               state_in = kst_pkg::ST_READ;
            end
         end
         kst_pkg::ST_COMMIT: begin
            state_in = kst_pkg::ST_DONE;
         end
         kst_pkg::ST_DONE: begin
            if (!stat.out_busy) begin
               state_in = kst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kst_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         kst_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         kst_pkg::ST_READ: begin
            cmd.read = 1'b1;
         end
         kst_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
         end
         kst_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
         end
         kst_pkg::ST_DONE: begin
            cmd.load = !stat.out_busy;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

/* rtl/kst_path.sv */
// slot storage, scan datapath and result register
module kst_path (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            req_mode,
   input  logic [31:0]           req_now_seconds,
   input  logic [31:0]           req_key_nonce,
   input  logic [7:0]            req_cipher_kind,
   input  logic [7:0]            req_key_table_index,
   input  logic [31:0]           req_table_handle,
   input  logic [7:0]            req_xor_variant,
   input  logic [7:0]            req_client_kind,
   input  logic                  csr_write_enable,
   input  logic [15:0]           csr_write_data,
   input  kst_pkg::ctrl_cmd_type  cmd,
   output kst_pkg::ctrl_stat_type stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [31:0]           rsp_result_nonce,
   output logic [3:0]            rsp_slot_index,
   output logic [7:0]            rsp_out_cipher_kind,
   output logic [7:0]            rsp_out_key_table_index,
   output logic [31:0]           rsp_out_table_handle,
   output logic [7:0]            rsp_out_xor_variant,
   output logic [7:0]            rsp_out_client_kind,
   output logic [31:0]           rsp_out_created_time
);

   logic [15:0]                     expiry_ff;
   logic [1:0]                      mode_ff;
   kst_pkg::entry_type              new_ff;
   logic [kst_pkg::SLOT_W-1:0]      idx_ff;
   logic [kst_pkg::SLOT_W-1:0]      target_ff;
   logic [kst_pkg::SLOT_W-1:0]      oldest_idx_ff;
   logic [31:0]                     oldest_time_ff;
   logic                            free_found_ff;
   logic                            hit_ff;
   logic [kst_pkg::TABLE_SLOTS-1:0] valid_ff;
   kst_pkg::entry_type              mem [kst_pkg::TABLE_SLOTS];
   kst_pkg::entry_type              rd_ff;
   logic                            rsp_valid_ff;
   logic [1:0]                      status_ff;
   logic [3:0]                      slot_ff;
   kst_pkg::entry_type              out_ff;

   logic                            is_create;
   logic                            is_find;
   logic                            is_remove;
   logic                            occupied;
   logic [31:0]                     age;
   logic                            expired;
   logic                            is_free;
   logic                            match;
   logic                            older;
   logic [kst_pkg::SLOT_W-1:0]      sel;
   logic [1:0]                      status_in;
   kst_pkg::entry_type              out_in;

   assign is_create = (mode_ff == kst_pkg::MODE_CREATE);
   assign is_find   = (mode_ff == kst_pkg::MODE_FIND);
   assign is_remove = (mode_ff == kst_pkg::MODE_REMOVE);

   assign occupied = valid_ff[idx_ff];
   assign age      = new_ff.created - rd_ff.created;
   assign expired  = is_create && occupied && (age > {16'd0, expiry_ff});
   assign is_free  = !occupied || expired;
   assign match    = (is_find || is_remove) && occupied && (new_ff.key != 32'd0)
                     && (rd_ff.key == new_ff.key);
   assign older    = (idx_ff == '0) || (rd_ff.created < oldest_time_ff);
   assign sel      = free_found_ff ? target_ff : oldest_idx_ff;

   assign stat.is_create = is_create;
   assign stat.is_remove = is_remove;
   assign stat.match     = match;
   assign stat.last      = (idx_ff == kst_pkg::SLOT_W'(kst_pkg::TABLE_SLOTS - 1));
   assign stat.out_busy  = rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         expiry_ff <= kst_pkg::EXPIRY_RESET;
      end else if (csr_write_enable) begin
         expiry_ff <= csr_write_data;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mode_ff          <= req_mode;
         new_ff.key       <= req_key_nonce;
         new_ff.created   <= req_now_seconds;
         new_ff.cipher    <= req_cipher_kind;
         new_ff.key_index <= req_key_table_index;
         new_ff.handle    <= req_table_handle;
         new_ff.xor_kind  <= req_xor_variant;
         new_ff.client    <= req_client_kind;
      end
   end

   // scan bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         free_found_ff <= 1'b0;
         hit_ff        <= 1'b0;
      end else if (cmd.start) begin
         idx_ff        <= '0;
         free_found_ff <= 1'b0;
         hit_ff        <= 1'b0;
      end else if (cmd.eval) begin
         idx_ff <= idx_ff + 1'b1;
         if (is_create && is_free && !free_found_ff) begin
            free_found_ff <= 1'b1;
         end
         if (match) begin
            hit_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         if ((is_create && is_free && !free_found_ff) || match) begin
            target_ff <= idx_ff;
         end
         if (is_create && occupied && !expired && older) begin
            oldest_idx_ff  <= idx_ff;
            oldest_time_ff <= rd_ff.created;
         end
      end else if (cmd.commit && is_create) begin
         target_ff <= sel;
      end
   end

   // occupancy; an entry without its bit set counts as empty
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.eval && expired) begin
         valid_ff[idx_ff] <= 1'b0;
      end else if (cmd.commit && is_create) begin
         valid_ff[sel] <= 1'b1;
      end else if (cmd.commit && is_remove) begin
         valid_ff[target_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && is_create) begin
         mem[sel] <= '{key:       (new_ff.key == 32'd0) ? 32'd1 : new_ff.key,
                       created:   new_ff.created,
                       cipher:    new_ff.cipher,
                       key_index: new_ff.key_index,
                       handle:    new_ff.handle,
                       xor_kind:  new_ff.xor_kind,
                       client:    new_ff.client};
      end
      if (cmd.read) begin
         rd_ff <= mem[idx_ff];
      end
   end

   always_comb begin
      status_in = kst_pkg::STATUS_NOT_FOUND;
      out_in    = '0;
      if (is_create) begin
         status_in  = kst_pkg::STATUS_CREATED;
         out_in     = new_ff;
         out_in.key = (new_ff.key == 32'd0) ? 32'd1 : new_ff.key;
      end else if (hit_ff && is_find) begin
         status_in = kst_pkg::STATUS_FOUND;
         out_in    = rd_ff;
      end else if (hit_ff && is_remove) begin
         status_in  = kst_pkg::STATUS_REMOVED;
         out_in.key = rd_ff.key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         status_ff <= status_in;
         out_ff    <= out_in;
         slot_ff   <= (status_in == kst_pkg::STATUS_NOT_FOUND) ? 4'd0
                      : kst_pkg::slot_to_index(target_ff);
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_status              = status_ff;
   assign rsp_result_nonce        = out_ff.key;
   assign rsp_slot_index          = slot_ff;
   assign rsp_out_cipher_kind     = out_ff.cipher;
   assign rsp_out_key_table_index = out_ff.key_index;
   assign rsp_out_table_handle    = out_ff.handle;
   assign rsp_out_xor_variant     = out_ff.xor_kind;
   assign rsp_out_client_kind     = out_ff.client;
   assign rsp_out_created_time    = out_ff.created;

endmodule

/* rtl/keyed_session_table_with_aging.sv */
// top level of the keyed session table with aging
// scan: a read state then an evaluate state per slot, over the whole table for create and
//   misses, then a commit state for create and a removal hit, and a load state for the result
// throughput: one request at a time, the next accepted the cycle after the result
//   is loaded; the single read port of the slot memory sets the read and evaluate step
// reset: synchronous; all slots empty, expiry register back to 30 seconds
module keyed_session_table_with_aging (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_now_seconds,
   input  logic [31:0] req_key_nonce,
   input  logic [7:0]  req_cipher_kind,
   input  logic [7:0]  req_key_table_index,
   input  logic [31:0] req_table_handle,
   input  logic [7:0]  req_xor_variant,
   input  logic [7:0]  req_client_kind,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_result_nonce,
   output logic [3:0]  rsp_slot_index,
   output logic [7:0]  rsp_out_cipher_kind,
   output logic [7:0]  rsp_out_key_table_index,
   output logic [31:0] rsp_out_table_handle,
   output logic [7:0]  rsp_out_xor_variant,
   output logic [7:0]  rsp_out_client_kind,
   output logic [31:0] rsp_out_created_time,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   kst_pkg::ctrl_cmd_type  cmd;
   kst_pkg::ctrl_stat_type stat;

   kst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   kst_path u_path (
      .clock                   (clock),
      .reset                   (reset),
      .req_mode                (req_mode),
      .req_now_seconds         (req_now_seconds),
      .req_key_nonce           (req_key_nonce),
      .req_cipher_kind         (req_cipher_kind),
      .req_key_table_index     (req_key_table_index),
      .req_table_handle        (req_table_handle),
      .req_xor_variant         (req_xor_variant),
      .req_client_kind         (req_client_kind),
      .csr_write_enable        (csr_write_enable),
      .csr_write_data          (csr_write_data),
      .cmd                     (cmd),
      .stat                    (stat),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_status              (rsp_status),
      .rsp_result_nonce        (rsp_result_nonce),
      .rsp_slot_index          (rsp_slot_index),
      .rsp_out_cipher_kind     (rsp_out_cipher_kind),
      .rsp_out_key_table_index (rsp_out_key_table_index),
      .rsp_out_table_handle    (rsp_out_table_handle),
      .rsp_out_xor_variant     (rsp_out_xor_variant),
      .rsp_out_client_kind     (rsp_out_client_kind),
      .rsp_out_created_time    (rsp_out_created_time)
   );

endmodule

/* rtl/kst_checker.sv */
// port-level checks for the keyed session table, bound to the top level
module kst_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_result_nonce,
   input logic [3:0]  rsp_slot_index,
   input logic [31:0] rsp_out_table_handle,
   input logic [31:0] rsp_out_created_time
);

   // a held response keeps its status
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response changed while stalled");

   // one request at a time: busy right after a request is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   // a created entry never carries the empty key
   a_created_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == kst_pkg::STATUS_CREATED |-> rsp_result_nonce != 32'd0)
      else $error("created entry with empty key");

   // a miss reports nothing
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == kst_pkg::STATUS_NOT_FOUND
      |-> rsp_result_nonce == 32'd0 && rsp_slot_index == 4'd0)
      else $error("miss with nonzero fields");

   // a removal reports the key and slot only
   a_remove_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == kst_pkg::STATUS_REMOVED
      |-> rsp_out_created_time == 32'd0 && rsp_out_table_handle == 32'd0
          && rsp_result_nonce != 32'd0)
      else $error("removal with payload fields");

endmodule

bind keyed_session_table_with_aging kst_checker u_kst_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_status           (rsp_status),
   .rsp_result_nonce     (rsp_result_nonce),
   .rsp_slot_index       (rsp_slot_index),
   .rsp_out_table_handle (rsp_out_table_handle),
   .rsp_out_created_time (rsp_out_created_time)
);
